/* rtl/core/fbs_pkg.sv */
// Shared types and constants for the fertigation batch sequencer.
package fbs_pkg;

    localparam int unsigned TimeBitsDefault = 32;
    localparam int unsigned RecipeWords     = 17;
    localparam int unsigned RecipeIdxW      = 5;
    localparam logic [31:0] MsPerMin        = 32'd60000;
    localparam logic [31:0] AllOnes         = 32'hFFFF_FFFF;
    localparam logic [31:0] MaxDoseMl       = 32'd71582;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_RESET = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_INIT_FILL   = 4'd1,
        PH_PRE_MIX     = 4'd2,
        PH_DOSE_A      = 4'd3,
        PH_MIX_A       = 4'd4,
        PH_DOSE_B      = 4'd5,
        PH_MIX_B       = 4'd6,
        PH_FINAL_FILL  = 4'd7,
        PH_FINAL_MIX   = 4'd8,
        PH_IRRIGATION  = 4'd9,
        PH_RINSE_FILL  = 4'd10,
        PH_RINSE_MIX   = 4'd11,
        PH_RINSE_DRAIN = 4'd12,
        PH_COMPLETE    = 4'd13,
        PH_FAULT       = 4'd14
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD_A, S_DIV_A, S_LOAD_B, S_DIV_B, S_CHECK,
        S_STEP, S_SNAP, S_OUT
    } t_seq_state;

    localparam logic [3:0] FLT_NONE    = 4'd0;
    localparam logic [3:0] FLT_INVALID = 4'd1;
    localparam logic [3:0] FLT_IO      = 4'd3;
    localparam logic [3:0] FLT_LEAK    = 4'd4;
    localparam logic [3:0] FLT_ESTOP   = 4'd5;
    localparam logic [3:0] FLT_TIMEOUT = 4'd12;

    localparam logic [4:0] R_TOTAL       = 5'd0;
    localparam logic [4:0] R_INITIAL     = 5'd1;
    localparam logic [4:0] R_NUT_A       = 5'd2;
    localparam logic [4:0] R_RATE_A      = 5'd3;
    localparam logic [4:0] R_NUT_B       = 5'd4;
    localparam logic [4:0] R_RATE_B      = 5'd5;
    localparam logic [4:0] R_INIT_FILL   = 5'd6;
    localparam logic [4:0] R_PRE_MIX     = 5'd7;
    localparam logic [4:0] R_MIX_A       = 5'd8;
    localparam logic [4:0] R_MIX_B       = 5'd9;
    localparam logic [4:0] R_FINAL_FILL  = 5'd10;
    localparam logic [4:0] R_FINAL_MIX   = 5'd11;
    localparam logic [4:0] R_IRRIG       = 5'd12;
    localparam logic [4:0] R_RINSE       = 5'd13;
    localparam logic [4:0] R_RINSE_FILL  = 5'd14;
    localparam logic [4:0] R_RINSE_MIX   = 5'd15;
    localparam logic [4:0] R_RINSE_DRAIN = 5'd16;

    localparam logic [2:0] CFG_MAX_WATER  = 3'd0;
    localparam logic [2:0] CFG_MAX_NUT    = 3'd1;
    localparam logic [2:0] CFG_NO_FLOW    = 3'd2;
    localparam logic [2:0] CFG_MAX_FILL   = 3'd3;
    localparam logic [2:0] CFG_MAX_BATCH  = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic        io_ok;
        logic        leak_seen;
        logic        estop;
        logic        tank_is_empty;
        logic        tank_is_full;
        logic [31:0] inlet_volume;
        logic [4:0]  recipe_index;
        logic [31:0] recipe_value;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  phase;
        logic [3:0]  fault_code;
        logic        water_valve;
        logic        mixer_on;
        logic        dose_a_pump;
        logic        dose_b_pump;
        logic        irrigation_pump;
        logic [31:0] phase_ms;
        logic [31:0] batch_ms;
        logic [31:0] delivered_water;
        logic [31:0] target_water;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend_hi;
        logic [31:0] dividend_lo;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
        logic        overflow;
    } t_div_rsp;

endpackage

/* rtl/core/fbs_divider.sv */
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module fbs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbs_pkg::t_div_req i_req,
    output fbs_pkg::t_div_rsp o_rsp
);
    import fbs_pkg::*;

    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_shift;
    logic [33:0] n_diff;

    always_comb begin
        n_shift = {r_rem[31:0], r_quo[63]};
        n_diff  = {1'b0, n_shift} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= {i_req.dividend_hi, i_req.dividend_lo};
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            if (!n_diff[33]) begin
                r_rem <= n_diff[32:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[31:0];
    assign o_rsp.overflow = |r_quo[63:32];

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

    property p_no_busy_done;
        @(posedge i_clk) disable iff (!i_rst_n) !(r_busy && r_done);
    endproperty
    a_no_busy_done: assert property (p_no_busy_done) else $error("busy and done together");

    property p_count_zero_idle;
        @(posedge i_clk) disable iff (!i_rst_n) !r_busy && !$past(i_req.start) |-> r_cnt == 7'd0;
    endproperty
    a_count_zero_idle: assert property (p_count_zero_idle) else $error("count left over");

endmodule

/* rtl/core/fertigation_batch_sequencer_top.sv */
// Top level of the fertigation batch sequencer: control FSM, recipe store, limits.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------
//  input    | i_in_valid/o_in_ready | i_in  (t_in_item)
//  output   | o_out_valid/i_out_ready | o_out (t_out_item)
//  config   | i_cfg_we              | i_cfg_idx, i_cfg_data
//
//  Tick, reset and write pass through the step and snapshot states; start first runs
//  two passes of the single bit-serial divider, one for each dose.
//  One transaction is in work at a time; ready is low until its result is taken.
//  Reset is synchronous; the recipe store is not cleared.
//  A stalled output holds the result and blocks the next input.
module fertigation_batch_sequencer_top #(
    parameter int unsigned TIME_BITS = fbs_pkg::TimeBitsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fbs_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fbs_pkg::t_out_item  o_out,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import fbs_pkg::*;

    localparam logic [31:0] TimeMask = 32'hFFFF_FFFF >> (32 - TIME_BITS);

    t_seq_state  r_state, n_state;
    t_in_item    r_in;
    t_out_item   r_out;
    logic [31:0] r_store [RecipeWords];
    logic [31:0] r_max_water, r_max_nut, r_no_flow, r_max_fill, r_max_batch;
    logic [31:0] r_dose_a, r_dose_b;
    t_phase      r_phase;
    logic [3:0]  r_fault;
    logic [4:0]  r_act;
    logic [31:0] r_phase_start, r_batch_start, r_flow_base, r_last_flow;
    logic        r_acc;
    logic [31:0] r_num, r_rate;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic [31:0] dose_val;
    logic [63:0] num_prod;
    logic        active;
    logic [31:0] phase_el, batch_el, el_thr;
    logic        safe;
    logic        rec_ok;
    logic [31:0] rs [RecipeWords];

    fbs_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_comb begin
        for (int k = 0; k < RecipeWords; k++) begin
            rs[k] = r_store[k];
        end
    end

    assign active   = (r_phase != PH_IDLE) && (r_phase != PH_COMPLETE) && (r_phase != PH_FAULT);
    assign phase_el = (r_in.now_ms - r_phase_start) & TimeMask;
    assign batch_el = (r_phase == PH_IDLE) ? 32'd0 : ((r_in.now_ms - r_batch_start) & TimeMask);
    assign safe     = r_in.io_ok && !r_in.leak_seen && !r_in.estop && r_in.tank_is_empty
                      && !r_in.tank_is_full;

    assign num_prod = r_num * MsPerMin + {32'd0, r_rate} - 64'd1;
    assign dose_val = (r_num == 32'd0) ? 32'd0 :
                      ((r_rate == 32'd0) || (r_num > MaxDoseMl)) ? AllOnes :
                      div_rsp.quotient;

    always_comb begin
        div_req             = '0;
        div_req.dividend_hi = num_prod[63:32];
        div_req.dividend_lo = num_prod[31:0];
        div_req.divisor     = r_rate;
        div_req.start       = ((r_state == S_DIV_A) || (r_state == S_DIV_B)) && !div_rsp.busy
                              && !div_rsp.done;
    end

    always_comb begin
        rec_ok = 1'b1;
        if (r_max_water == 0 || r_max_nut == 0 || r_no_flow == 0 || r_max_fill == 0
            || r_max_batch == 0) rec_ok = 1'b0;
        if (rs[R_TOTAL] == 0 || rs[R_TOTAL] > r_max_water || rs[R_INITIAL] == 0
            || rs[R_INITIAL] >= rs[R_TOTAL]) rec_ok = 1'b0;
        if (rs[R_NUT_A] > r_max_nut || rs[R_NUT_B] > r_max_nut) rec_ok = 1'b0;
        if ((rs[R_NUT_A] != 0 && rs[R_RATE_A] == 0) || (rs[R_NUT_B] != 0 && rs[R_RATE_B] == 0))
            rec_ok = 1'b0;
        if (rs[R_INIT_FILL] == 0 || rs[R_FINAL_FILL] == 0 || rs[R_PRE_MIX] == 0
            || rs[R_FINAL_MIX] == 0 || rs[R_IRRIG] == 0) rec_ok = 1'b0;
        if (rs[R_RINSE] > r_max_water || (rs[R_RINSE] != 0 && (rs[R_RINSE_FILL] == 0
            || rs[R_RINSE_MIX] == 0 || rs[R_RINSE_DRAIN] == 0))) rec_ok = 1'b0;
        if (r_dose_a == AllOnes || r_dose_b == AllOnes) rec_ok = 1'b0;
    end

    always_comb begin
        case (r_phase)
            PH_INIT_FILL:   el_thr = rs[R_INIT_FILL];
            PH_PRE_MIX:     el_thr = rs[R_PRE_MIX];
            PH_DOSE_A:      el_thr = r_dose_a;
            PH_MIX_A:       el_thr = rs[R_MIX_A];
            PH_DOSE_B:      el_thr = r_dose_b;
            PH_MIX_B:       el_thr = rs[R_MIX_B];
            PH_FINAL_FILL:  el_thr = rs[R_FINAL_FILL];
            PH_FINAL_MIX:   el_thr = rs[R_FINAL_MIX];
            PH_IRRIGATION:  el_thr = rs[R_IRRIG];
            PH_RINSE_FILL:  el_thr = rs[R_RINSE_FILL];
            PH_RINSE_MIX:   el_thr = rs[R_RINSE_MIX];
            PH_RINSE_DRAIN: el_thr = rs[R_RINSE_DRAIN];
            default:        el_thr = AllOnes;
        endcase
    end

    function automatic logic [4:0] act_of(t_phase ph);
        logic [4:0] a;
        case (ph)
            PH_INIT_FILL, PH_RINSE_FILL: a = 5'b00001;
            PH_PRE_MIX, PH_MIX_A, PH_MIX_B, PH_FINAL_MIX, PH_RINSE_MIX: a = 5'b00010;
            PH_DOSE_A:     a = 5'b00110;
            PH_DOSE_B:     a = 5'b01010;
            PH_FINAL_FILL: a = 5'b00011;
            PH_IRRIGATION, PH_RINSE_DRAIN: a = 5'b10000;
            default:       a = 5'b00000;
        endcase
        return a;
    endfunction

    function automatic t_phase next_of(t_phase ph, logic nut_a, logic nut_b, logic rinse);
        t_phase p;
        case (ph)
            PH_INIT_FILL:   p = PH_PRE_MIX;
            PH_PRE_MIX:     p = nut_a ? PH_DOSE_A : PH_MIX_A;
            PH_DOSE_A:      p = PH_MIX_A;
            PH_MIX_A:       p = nut_b ? PH_DOSE_B : PH_MIX_B;
            PH_DOSE_B:      p = PH_MIX_B;
            PH_MIX_B:       p = PH_FINAL_FILL;
            PH_FINAL_FILL:  p = PH_FINAL_MIX;
            PH_FINAL_MIX:   p = PH_IRRIGATION;
            PH_IRRIGATION:  p = rinse ? PH_RINSE_FILL : PH_COMPLETE;
            PH_RINSE_FILL:  p = PH_RINSE_MIX;
            PH_RINSE_MIX:   p = PH_RINSE_DRAIN;
            PH_RINSE_DRAIN: p = PH_COMPLETE;
            default:        p = ph;
        endcase
        return p;
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_action'(i_in.action) == ACT_START) ? S_LOAD_A : S_STEP;
                end
            end
            S_LOAD_A: n_state = S_DIV_A;
            S_DIV_A: begin
                if (div_rsp.done) begin
                    n_state = S_LOAD_B;
                end
            end
            S_LOAD_B: n_state = S_DIV_B;
            S_DIV_B: begin
                if (div_rsp.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = S_SNAP;
            S_STEP:  n_state = S_SNAP;
            S_SNAP:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_water <= '0;
            r_max_nut   <= '0;
            r_no_flow   <= '0;
            r_max_fill  <= '0;
            r_max_batch <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_WATER: r_max_water <= i_cfg_data;
                CFG_MAX_NUT:   r_max_nut   <= i_cfg_data;
                CFG_NO_FLOW:   r_no_flow   <= i_cfg_data;
                CFG_MAX_FILL:  r_max_fill  <= i_cfg_data;
                CFG_MAX_BATCH: r_max_batch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_STEP && t_action'(r_in.action) == ACT_WRITE && !active
            && r_in.recipe_index < RecipeIdxW'(RecipeWords)) begin
            r_store[r_in.recipe_index] <= r_in.recipe_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in;
        end
        if (r_state == S_LOAD_A) begin
            r_num  <= rs[R_NUT_A];
            r_rate <= rs[R_RATE_A];
        end
        if (r_state == S_LOAD_B) begin
            r_num  <= rs[R_NUT_B];
            r_rate <= rs[R_RATE_B];
        end
        if (r_state == S_SNAP) begin
            r_out.accepted        <= r_acc;
            r_out.phase           <= r_phase;
            r_out.fault_code      <= r_fault;
            r_out.water_valve     <= r_act[0];
            r_out.mixer_on        <= r_act[1];
            r_out.dose_a_pump     <= r_act[2];
            r_out.dose_b_pump     <= r_act[3];
            r_out.irrigation_pump <= r_act[4];
            r_out.phase_ms        <= phase_el;
            r_out.batch_ms        <= batch_el;
            r_out.delivered_water <= r_last_flow - r_flow_base;
            r_out.target_water    <= (r_phase == PH_INIT_FILL) ? rs[R_INITIAL] :
                                     (r_phase == PH_RINSE_FILL) ? rs[R_RINSE] : rs[R_TOTAL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_fault       <= FLT_NONE;
            r_act         <= '0;
            r_dose_a      <= '0;
            r_dose_b      <= '0;
            r_phase_start <= '0;
            r_batch_start <= '0;
            r_flow_base   <= '0;
            r_last_flow   <= '0;
            r_acc         <= 1'b0;
        end else begin
            case (r_state)
                S_DIV_A: begin
                    if (div_rsp.done) begin
                        r_dose_a <= (div_rsp.overflow && dose_val == div_rsp.quotient)
                                    ? AllOnes : dose_val;
                    end
                end
                S_DIV_B: begin
                    if (div_rsp.done) begin
                        r_dose_b <= (div_rsp.overflow && dose_val == div_rsp.quotient)
                                    ? AllOnes : dose_val;
                    end
                end
                S_CHECK: begin
                    r_batch_start <= r_in.now_ms;
                    r_phase_start <= r_in.now_ms;
                    r_flow_base   <= r_in.inlet_volume;
                    r_last_flow   <= r_in.inlet_volume;
                    if (rec_ok) begin
                        r_phase <= PH_INIT_FILL;
                        r_fault <= FLT_NONE;
                        r_act   <= act_of(PH_INIT_FILL);
                        r_acc   <= 1'b1;
                    end else begin
                        r_phase <= PH_FAULT;
                        r_fault <= FLT_INVALID;
                        r_act   <= '0;
                        r_acc   <= 1'b0;
                    end
                end
                S_STEP: begin
                    case (t_action'(r_in.action))
                        ACT_TICK: begin
                            r_acc <= 1'b1;
                            if (active) begin
                                if (!r_in.io_ok || r_in.leak_seen || r_in.estop
                                    || batch_el >= r_max_batch) begin
                                    r_fault <= !r_in.io_ok ? FLT_IO :
                                               r_in.leak_seen ? FLT_LEAK :
                                               r_in.estop ? FLT_ESTOP : FLT_TIMEOUT;
                                    r_phase       <= PH_FAULT;
                                    r_phase_start <= r_in.now_ms;
                                    r_act         <= '0;
                                end else if (phase_el >= el_thr) begin
                                    r_phase <= next_of(r_phase, rs[R_NUT_A] != 0,
                                                       rs[R_NUT_B] != 0, rs[R_RINSE] != 0);
                                    r_act   <= act_of(next_of(r_phase, rs[R_NUT_A] != 0,
                                                       rs[R_NUT_B] != 0, rs[R_RINSE] != 0));
                                    r_phase_start <= r_in.now_ms;
                                    if (r_phase == PH_MIX_B || (r_phase == PH_IRRIGATION
                                        && rs[R_RINSE] != 0)) begin
                                        r_last_flow <= r_in.inlet_volume;
                                    end
                                end
                            end
                        end
                        ACT_RESET: begin
                            r_acc <= safe;
                            if (safe) begin
                                r_phase <= PH_IDLE;
                                r_fault <= FLT_NONE;
                                r_act   <= '0;
                            end
                        end
                        ACT_WRITE: begin
                            r_acc <= !active && r_in.recipe_index < RecipeIdxW'(RecipeWords);
                        end
                        default: r_acc <= 1'b0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    property p_ready_only_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_in_ready |-> !o_out_valid;
    endproperty
    a_ready_only_idle: assert property (p_ready_only_idle) else $error("ready while result held");

    property p_fault_phase;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_fault != FLT_NONE) |-> (r_phase == PH_FAULT);
    endproperty
    a_fault_phase: assert property (p_fault_phase) else $error("fault code outside fault phase");

    property p_act_off_idle;
        @(posedge i_clk) disable iff (!i_rst_n) !active |-> r_act == 5'd0;
    endproperty
    a_act_off_idle: assert property (p_act_off_idle) else $error("actuator on while inactive");

endmodule

/* verif/fbs_checker.sv */
// Checker for the fertigation batch sequencer: predicts every snapshot and compares it.
`timescale 1ns / 1ps
module fbs_checker
    import fbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0] lim_water, lim_nut, lim_noflow, lim_fill, lim_batch;
    logic [31:0] recipe [RecipeWords];
    logic [31:0] dose_a_ms, dose_b_ms;
    t_phase      cur_phase;
    logic [3:0]  cur_fault;
    logic        act_water, act_mixer, act_a, act_b, act_irr;
    logic [31:0] phase_t0, batch_t0, flow_base, flow_last;
    t_out_item   snapshots_due[$];

    function automatic logic [31:0] dose_time(logic [31:0] ml, logic [31:0] rate);
        logic [63:0] num;
        if (ml == 0) return 0;
        if (rate == 0 || ml > MaxDoseMl) return AllOnes;
        num = 64'(ml) * 64'd60000;
        return 32'((num + 64'(rate) - 1) / 64'(rate));
    endfunction

    function automatic logic recipe_passes();
        if (lim_water == 0 || lim_nut == 0 || lim_noflow == 0 || lim_fill == 0 ||
            lim_batch == 0) return 0;
        if (recipe[R_TOTAL] == 0 || recipe[R_TOTAL] > lim_water ||
            recipe[R_INITIAL] == 0 || recipe[R_INITIAL] >= recipe[R_TOTAL]) return 0;
        if (recipe[R_NUT_A] > lim_nut || recipe[R_NUT_B] > lim_nut) return 0;
        if ((recipe[R_NUT_A] > 0 && recipe[R_RATE_A] == 0) ||
            (recipe[R_NUT_B] > 0 && recipe[R_RATE_B] == 0)) return 0;
        if (recipe[R_INIT_FILL] == 0 || recipe[R_FINAL_FILL] == 0 || recipe[R_PRE_MIX] == 0 ||
            recipe[R_FINAL_MIX] == 0 || recipe[R_IRRIG] == 0) return 0;
        if (recipe[R_RINSE] > lim_water || (recipe[R_RINSE] > 0 &&
            (recipe[R_RINSE_FILL] == 0 || recipe[R_RINSE_MIX] == 0 ||
             recipe[R_RINSE_DRAIN] == 0))) return 0;
        return dose_a_ms != AllOnes && dose_b_ms != AllOnes;
    endfunction

    function automatic logic batch_running();
        return cur_phase != PH_IDLE && cur_phase != PH_COMPLETE && cur_phase != PH_FAULT;
    endfunction

    task automatic enter_phase(t_phase ph, logic [31:0] now, logic [31:0] flow);
        cur_phase = ph;
        phase_t0  = now;
        if (ph == PH_INIT_FILL || ph == PH_FINAL_FILL || ph == PH_RINSE_FILL) flow_last = flow;
        act_water = ph inside {PH_INIT_FILL, PH_RINSE_FILL, PH_FINAL_FILL};
        act_mixer = ph inside {PH_PRE_MIX, PH_MIX_A, PH_MIX_B, PH_FINAL_MIX, PH_RINSE_MIX,
                               PH_DOSE_A, PH_DOSE_B, PH_FINAL_FILL};
        act_a     = ph == PH_DOSE_A;
        act_b     = ph == PH_DOSE_B;
        act_irr   = ph inside {PH_IRRIGATION, PH_RINSE_DRAIN};
    endtask

    task automatic raise_fault(logic [3:0] code, logic [31:0] now);
        cur_fault = code;
        cur_phase = PH_FAULT;
        phase_t0  = now;
        {act_water, act_mixer, act_a, act_b, act_irr} = '0;
    endtask

    task automatic step_phase(logic [31:0] now, logic [31:0] flow);
        logic [31:0] el;
        el = now - phase_t0;
        case (cur_phase)
            PH_INIT_FILL:   if (el >= recipe[R_INIT_FILL]) enter_phase(PH_PRE_MIX, now, flow);
            PH_PRE_MIX:     if (el >= recipe[R_PRE_MIX])
                                enter_phase(recipe[R_NUT_A] > 0 ? PH_DOSE_A : PH_MIX_A, now, flow);
            PH_DOSE_A:      if (el >= dose_a_ms) enter_phase(PH_MIX_A, now, flow);
            PH_MIX_A:       if (el >= recipe[R_MIX_A])
                                enter_phase(recipe[R_NUT_B] > 0 ? PH_DOSE_B : PH_MIX_B, now, flow);
            PH_DOSE_B:      if (el >= dose_b_ms) enter_phase(PH_MIX_B, now, flow);
            PH_MIX_B:       if (el >= recipe[R_MIX_B]) enter_phase(PH_FINAL_FILL, now, flow);
            PH_FINAL_FILL:  if (el >= recipe[R_FINAL_FILL]) enter_phase(PH_FINAL_MIX, now, flow);
            PH_FINAL_MIX:   if (el >= recipe[R_FINAL_MIX]) enter_phase(PH_IRRIGATION, now, flow);
            PH_IRRIGATION:  if (el >= recipe[R_IRRIG])
                                enter_phase(recipe[R_RINSE] > 0 ? PH_RINSE_FILL : PH_COMPLETE,
                                            now, flow);
            PH_RINSE_FILL:  if (el >= recipe[R_RINSE_FILL]) enter_phase(PH_RINSE_MIX, now, flow);
            PH_RINSE_MIX:   if (el >= recipe[R_RINSE_MIX]) enter_phase(PH_RINSE_DRAIN, now, flow);
            PH_RINSE_DRAIN: if (el >= recipe[R_RINSE_DRAIN]) enter_phase(PH_COMPLETE, now, flow);
            default: ;
        endcase
    endtask

    function automatic logic [31:0] batch_time(logic [31:0] now);
        return cur_phase == PH_IDLE ? 32'd0 : now - batch_t0;
    endfunction

    task automatic predict_snapshot(t_in_item it);
        t_out_item s;
        s.accepted = 0;
        case (t_action'(it.action))
            ACT_TICK: begin
                s.accepted = 1;
                if (batch_running()) begin
                    if (!it.io_ok) raise_fault(FLT_IO, it.now_ms);
                    else if (it.leak_seen) raise_fault(FLT_LEAK, it.now_ms);
                    else if (it.estop) raise_fault(FLT_ESTOP, it.now_ms);
                    else if (batch_time(it.now_ms) >= lim_batch)
                        raise_fault(FLT_TIMEOUT, it.now_ms);
                    else step_phase(it.now_ms, it.inlet_volume);
                end
            end
            ACT_START: begin
                batch_t0  = it.now_ms;
                phase_t0  = it.now_ms;
                flow_base = it.inlet_volume;
                flow_last = it.inlet_volume;
                cur_fault = FLT_NONE;
                {act_water, act_mixer, act_a, act_b, act_irr} = '0;
                dose_a_ms = dose_time(recipe[R_NUT_A], recipe[R_RATE_A]);
                dose_b_ms = dose_time(recipe[R_NUT_B], recipe[R_RATE_B]);
                if (recipe_passes()) begin
                    enter_phase(PH_INIT_FILL, it.now_ms, it.inlet_volume);
                    s.accepted = 1;
                end else begin
                    raise_fault(FLT_INVALID, it.now_ms);
                end
            end
            ACT_RESET: begin
                if (it.io_ok && !it.leak_seen && !it.estop && it.tank_is_empty &&
                    !it.tank_is_full) begin
                    cur_phase = PH_IDLE;
                    cur_fault = FLT_NONE;
                    {act_water, act_mixer, act_a, act_b, act_irr} = '0;
                    s.accepted = 1;
                end
            end
            default: begin
                if (!batch_running() && it.recipe_index < RecipeWords) begin
                    recipe[it.recipe_index] = it.recipe_value;
                    s.accepted = 1;
                end
            end
        endcase
        s.phase           = cur_phase;
        s.fault_code      = cur_fault;
        s.water_valve     = act_water;
        s.mixer_on        = act_mixer;
        s.dose_a_pump     = act_a;
        s.dose_b_pump     = act_b;
        s.irrigation_pump = act_irr;
        s.phase_ms        = it.now_ms - phase_t0;
        s.batch_ms        = batch_time(it.now_ms);
        s.delivered_water = flow_last - flow_base;
        s.target_water    = cur_phase == PH_INIT_FILL  ? recipe[R_INITIAL] :
                            cur_phase == PH_RINSE_FILL ? recipe[R_RINSE] : recipe[R_TOTAL];
        snapshots_due.push_back(s);
    endtask

    assign o_pending = snapshots_due.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            {lim_water, lim_nut, lim_noflow, lim_fill, lim_batch} = '0;
            dose_a_ms = 0;
            dose_b_ms = 0;
            cur_phase = PH_IDLE;
            cur_fault = FLT_NONE;
            {act_water, act_mixer, act_a, act_b, act_irr} = '0;
            {phase_t0, batch_t0, flow_base, flow_last} = '0;
            snapshots_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_WATER: lim_water  = i_cfg_data;
                    CFG_MAX_NUT:   lim_nut    = i_cfg_data;
                    CFG_NO_FLOW:   lim_noflow = i_cfg_data;
                    CFG_MAX_FILL:  lim_fill   = i_cfg_data;
                    CFG_MAX_BATCH: lim_batch  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (snapshots_due.size() == 0) begin
                    $display("%0t: unexpected snapshot %h", $time, i_out);
                    o_fail_count++;
                end else begin
                    want = snapshots_due.pop_front();
                    if (want !== i_out) begin
                        $display("%0t: snapshot mismatch expected %p actual %p",
                                 $time, want, i_out);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_snapshot(i_in);
        end
    end

endmodule

/* verif/fertigation_batch_sequencer_top_tb.sv */
// Testbench top for the fertigation batch sequencer: stimulus, reset and verdict.
`timescale 1ns / 1ps
module fertigation_batch_sequencer_top_tb;
    import fbs_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 0;
    t_out_item   out_item;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    bit          calm = 0;
    bit          hold_off = 0;
    logic [31:0] now_ms = 0;
    logic [31:0] meter = 0;

    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    fertigation_batch_sequencer_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    fbs_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge clk) begin
        if (hold_off) out_ready <= 0;
        else out_ready <= calm || $urandom_range(99) >= 38;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(t_action act, logic [4:0] idx = 0, logic [31:0] val = 0,
                        logic io = 1, logic lk = 0, logic es = 0,
                        logic emp = 1, logic ful = 0);
        t_in_item it;
        if (!calm) while ($urandom_range(99) < 38) @(negedge clk);
        it.action        = act;
        it.now_ms        = now_ms;
        it.io_ok         = io;
        it.leak_seen     = lk;
        it.estop         = es;
        it.tank_is_empty = emp;
        it.tank_is_full  = ful;
        it.inlet_volume  = meter;
        it.recipe_index  = idx;
        it.recipe_value  = val;
        in_item  <= it;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid <= 0;
        @(negedge clk);
    endtask

    task automatic set_limit(logic [2:0] idx, logic [31:0] val);
        cfg_we   <= 1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 0;
        @(negedge clk);
    endtask

    task automatic settle();
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_recipe(logic [31:0] total, logic [31:0] nut_a, logic [31:0] rate_a,
                                logic [31:0] nut_b, logic [31:0] rate_b, logic [31:0] rinse,
                                logic [31:0] step_ms);
        send(ACT_WRITE, R_TOTAL, total);
        send(ACT_WRITE, R_INITIAL, total / 2 + 1);
        send(ACT_WRITE, R_NUT_A, nut_a);
        send(ACT_WRITE, R_RATE_A, rate_a);
        send(ACT_WRITE, R_NUT_B, nut_b);
        send(ACT_WRITE, R_RATE_B, rate_b);
        for (int i = R_INIT_FILL; i <= R_IRRIG; i++)
            send(ACT_WRITE, 5'(i), $urandom_range(step_ms, 1));
        send(ACT_WRITE, R_RINSE, rinse);
        for (int i = R_RINSE_FILL; i <= R_RINSE_DRAIN; i++)
            send(ACT_WRITE, 5'(i), $urandom_range(step_ms, 0));
    endtask

    task automatic run_batch(int ticks);
        logic [4:0] r;
        now_ms = $urandom;
        send(ACT_START);
        for (int i = 0; i < ticks; i++) begin
            now_ms += $urandom_range(40, 0);
            meter  += $urandom_range(500, 0);
            r = 5'($urandom_range(31));
            if (r == 0) send(ACT_TICK, 0, 0, 0);
            else if (r == 1) send(ACT_TICK, 0, 0, 1, 1);
            else if (r == 2) send(ACT_TICK, 0, 0, 1, 0, 1);
            else if (r == 3) send(ACT_WRITE, 5'($urandom_range(31)), $urandom);
            else if (r == 4) send(ACT_START);
            else send(ACT_TICK, 0, 0, 1, 0, 0, $urandom_range(1), $urandom_range(1));
        end
        send(ACT_RESET, 0, 0, $urandom_range(1), $urandom_range(1), $urandom_range(1),
             $urandom_range(1), $urandom_range(1));
        send(ACT_RESET);
    endtask

    initial begin
        int limits [5];
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // zero limits reject the start; every store word written first
        calm = 1;
        write_recipe(32'hFFFF_FFFF, 0, 0, 32'd71582, 32'd1, 0, 5);
        send(ACT_START, 0, 0, 1, 0, 0, 1, 0);
        send(ACT_TICK);
        send(ACT_WRITE, 5'd17, AllOnes);
        send(ACT_WRITE, 5'd31, AllOnes);
        send(ACT_RESET, 0, 0, 1, 0, 0, 1, 1);
        send(ACT_RESET, 0, 0, 1, 0, 0, 0, 0);
        send(ACT_RESET);
        settle();

        set_limit(CFG_MAX_WATER, AllOnes);
        set_limit(CFG_MAX_NUT, AllOnes);
        set_limit(CFG_NO_FLOW, AllOnes);
        set_limit(CFG_MAX_FILL, AllOnes);
        set_limit(CFG_MAX_BATCH, AllOnes);
        send(ACT_START);
        send(ACT_RESET);
        write_recipe(1000, 32'd71583, 32'd7, 0, 0, 0, 5);
        send(ACT_START);
        send(ACT_RESET);
        write_recipe(1000, 5, 0, 0, 0, 0, 5);
        send(ACT_START);
        send(ACT_RESET);
        calm = 0;
        settle();

        for (int p = 0; p < 8; p++) begin
            limits[0] = p == 1 ? 1 : (p == 2 ? 0 : $urandom_range(50000, 2000));
            limits[1] = p == 3 ? 1 : $urandom_range(300, 1);
            limits[2] = p == 4 ? 0 : $urandom;
            limits[3] = $urandom_range(100) == 0 ? 0 : AllOnes;
            limits[4] = p == 5 ? $urandom_range(200, 20) : AllOnes;
            for (int i = 0; i < 5; i++) set_limit(3'(i), limits[i]);
            calm = p == 6;
            for (int b = 0; b < 2; b++) begin
                write_recipe($urandom_range(3000, 2), $urandom_range(3) == 0 ? 0 :
                             $urandom_range(300), $urandom_range(60000, 0),
                             $urandom_range(3) == 0 ? 0 : $urandom_range(300),
                             $urandom_range(60000, 1), $urandom_range(1) * 100, 60);
                if (p == 7 && b == 0) begin
                    fork
                        begin
                            hold_off = 1;
                            repeat (400) @(negedge clk);
                            hold_off = 0;
                        end
                        run_batch(15);
                    join
                end else begin
                    run_batch(10);
                end
            end
            settle();
        end

        calm = 0;
        settle();
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

/* fertigation_batch_sequencer_top.f */
rtl/core/fbs_pkg.sv
rtl/core/fbs_divider.sv
rtl/core/fertigation_batch_sequencer_top.sv
verif/fbs_checker.sv
verif/fertigation_batch_sequencer_top_tb.sv
